>>> hdl/nss_pkg.sv
// Shared types and fixed constants of the nearest segment search unit.
`default_nettype none

package nss_pkg;

    // Width and reset value of the distance limit register.
    localparam int LIMIT_W = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd8;

    // A candidate's nearest point must lie closer than 2**NEAR_LOG2 pixels in x and in y.
    localparam int NEAR_LOG2 = 8;

    // Result fields.
    localparam int OUT_FRAC   = 8;
    localparam int INDEX_W    = 10;
    localparam int DIST_OUT_W = 24;
    localparam int OUT_DATA_W = ((INDEX_W + DIST_OUT_W + 7) / 8) * 8;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

>>> hdl/nss_div.sv
// Restoring serial divider that forms one fraction bit of the projection factor per cycle.
`default_nettype none

module nss_div #(
    parameter int NUM_W = 33,
    parameter int QUO_W = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_W-1:0]     i_num,
    input  wire logic [NUM_W-1:0]     i_den,
    output logic      [QUO_W-1:0]     o_quo,
    output nss_pkg::t_div_status      o_status
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [NUM_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [NUM_W:0]   w_shift;
    logic [NUM_W:0]   w_diff;
    logic             w_ge;

    // The numerator is below the denominator, so the remainder always fits NUM_W bits.
    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, i_den};
    assign w_ge    = (w_shift >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[NUM_W-1:0] : w_shift[NUM_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_quo           = r_quo;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

`default_nettype wire

>>> hdl/nearest_segment_search_unit.sv
// Top level of the nearest segment search unit: sequencer, shared multiplier and search state.
`default_nettype none

// Usage:
// Each item on the s_axis channel carries the query point and one line segment; s_axis_tlast
// marks the final segment of a search. The unit projects the point onto the segment, forms
// the squared distance and keeps the strictly nearest segment closer than the limit
// written on i_cfg_we / i_cfg_wdata (pixels, reset 8).
// On the last segment one result item leaves on m_axis: tuser is the found flag, tdata holds
// the segment index and the squared distance with 8 fraction bits; the search then clears.
// The serial divider forms the projection factor unless the projection clamps to an end point;
// every multiply goes through the one shared multiplier in turn, and the divider yields one bit
// per cycle. s_axis_tready is high only while the unit waits for an item.
// The result sits in an output register, so the next item is taken while it waits; if a new
// result is due while that register is still full, the sequencer holds until it is taken.
// Reset is synchronous and active low: it clears the search, returns the limit to 8 and
// empties the output register.

module nearest_segment_search_unit #(
    parameter int COORD_BITS   = 16,
    parameter int FRAC_BITS    = 16,
    parameter int MAX_SEGMENTS = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // query_x, query_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y, from bit 0 up
    input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  wire logic                                   s_axis_tvalid,
    input  wire logic                                   s_axis_tlast,
    output logic                                        s_axis_tready,
    // best_index, best_dist_sq, from bit 0 up
    output logic [nss_pkg::OUT_DATA_W-1:0]              m_axis_tdata,
    // found
    output logic                                        m_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    input  wire logic                                   i_cfg_we,
    input  wire logic [nss_pkg::LIMIT_W-1:0]            i_cfg_wdata
);

    localparam int C        = COORD_BITS;
    localparam int F        = FRAC_BITS;
    localparam int SQ_IN_W  = F + nss_pkg::NEAR_LOG2;
    localparam int MW       = (C > SQ_IN_W) ? C : SQ_IN_W;
    localparam int PW       = 2 * MW;
    localparam int DOT_W    = 2 * C + 2;
    localparam int DEN_W    = 2 * C + 1;
    localparam int T_W      = F + 1;
    localparam int U_W      = C + F + 2;
    localparam int M_W      = C + F + 1;
    localparam int DIST_W   = 2 * SQ_IN_W + 1;
    localparam int CNT_W    = $clog2(MAX_SEGMENTS);
    localparam int IDX_X_W  = (CNT_W > nss_pkg::INDEX_W) ? CNT_W : nss_pkg::INDEX_W;
    localparam int LIM2_W   = 2 * nss_pkg::LIMIT_W;
    localparam int OUT_LSB  = 2 * F - nss_pkg::OUT_FRAC;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PX   = 4'd1;
    localparam logic [3:0] S_PY   = 4'd2;
    localparam logic [3:0] S_DXX  = 4'd3;
    localparam logic [3:0] S_DYY  = 4'd4;
    localparam logic [3:0] S_DEN  = 4'd5;
    localparam logic [3:0] S_TSEL = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_TX   = 4'd8;
    localparam logic [3:0] S_TY   = 4'd9;
    localparam logic [3:0] S_UY   = 4'd10;
    localparam logic [3:0] S_MX   = 4'd11;
    localparam logic [3:0] S_MY   = 4'd12;
    localparam logic [3:0] S_LIM  = 4'd13;
    localparam logic [3:0] S_CMP  = 4'd14;

    // Difference a - b as sign and magnitude; the magnitude always fits the coordinate width.
    function automatic logic [C:0] f_diff_sm(input logic [C-1:0] a, input logic [C-1:0] b);
        logic [C:0] p;
        logic [C:0] n;
        p = {a[C-1], a} - {b[C-1], b};
        n = {b[C-1], b} - {a[C-1], a};
        return p[C] ? {1'b1, n[C-1:0]} : {1'b0, p[C-1:0]};
    endfunction

    function automatic logic [U_W-1:0] f_sadd(input logic [U_W-1:0] a, input logic a_neg,
                                               input logic [U_W-1:0] b, input logic b_neg);
        logic [U_W-1:0] sa;
        logic [U_W-1:0] sb;
        sa = a_neg ? (U_W'(0) - a) : a;
        sb = b_neg ? (U_W'(0) - b) : b;
        return sa + sb;
    endfunction

    function automatic logic [M_W-1:0] f_abs(input logic [U_W-1:0] u);
        logic [U_W-1:0] n;
        n = U_W'(0) - u;
        return u[U_W-1] ? n[M_W-1:0] : u[M_W-1:0];
    endfunction

    logic [3:0]                     r_state;
    logic [3:0]                     n_state;

    logic [nss_pkg::LIMIT_W-1:0]    r_limit;

    logic [C-1:0]                   r_ax_mag, r_ay_mag, r_dx_mag, r_dy_mag;
    logic                           r_ax_neg, r_ay_neg, r_dx_neg, r_dy_neg;
    logic                           r_last;

    logic [PW-1:0]                  r_prod;
    logic [MW-1:0]                  w_mul_a;
    logic [MW-1:0]                  w_mul_b;
    logic                           w_mul_en;

    logic [DOT_W-1:0]               r_dot;
    logic [DEN_W-1:0]               r_den;
    logic [DOT_W-1:0]               w_term;
    logic                           w_dot_nonpos;
    logic                           w_dot_ge_den;
    logic                           w_div_start;

    logic [T_W-1:0]                 r_t;
    logic [F-1:0]                   w_div_quo;
    nss_pkg::t_div_status           w_div_sts;

    logic [U_W-1:0]                 r_ux, r_uy;
    logic [U_W-1:0]                 w_back_x, w_back_y, w_tprod;
    logic [M_W-1:0]                 r_mx, r_my;
    logic                           r_near_x, r_near_y;
    logic [DIST_W-1:0]              r_dist;
    logic [DIST_W-1:0]              w_sq;

    logic [DIST_W-1:0]              r_best_sq;
    logic [CNT_W-1:0]               r_best_pos;
    logic                           r_have_best;
    logic [CNT_W-1:0]               r_count;

    logic [DIST_W-1:0]              w_thr;
    logic                           w_cand;
    logic                           w_new_have;
    logic [DIST_W-1:0]              w_new_sq;
    logic [CNT_W-1:0]               w_new_pos;
    logic [IDX_X_W-1:0]             w_pos_ext;
    logic                           w_out_free;
    logic                           w_cmp_go;

    logic                           r_out_valid;
    logic                           r_out_found;
    logic [nss_pkg::INDEX_W-1:0]    r_out_index;
    logic [nss_pkg::DIST_OUT_W-1:0] r_out_dist;

    logic [C:0]                     w_ax_sm, w_ay_sm, w_dx_sm, w_dy_sm;

    assign w_ax_sm = f_diff_sm(s_axis_tdata[0*C +: C], s_axis_tdata[2*C +: C]);
    assign w_ay_sm = f_diff_sm(s_axis_tdata[1*C +: C], s_axis_tdata[3*C +: C]);
    assign w_dx_sm = f_diff_sm(s_axis_tdata[4*C +: C], s_axis_tdata[2*C +: C]);
    assign w_dy_sm = f_diff_sm(s_axis_tdata[5*C +: C], s_axis_tdata[3*C +: C]);

    assign s_axis_tready = (r_state == S_IDLE);

    // ---------------- sequencer ----------------
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_cmp_go   = (r_state == S_CMP) && (!r_last || w_out_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_axis_tvalid) begin
                n_state = S_PX;
            end
            S_PX:   n_state = S_PY;
            S_PY:   n_state = S_DXX;
            S_DXX:  n_state = S_DYY;
            S_DYY:  n_state = S_DEN;
            S_DEN:  n_state = S_TSEL;
            S_TSEL: n_state = w_div_start ? S_DIV : S_TX;
            S_DIV:  if (w_div_sts.done) begin
                n_state = S_TX;
            end
            S_TX:   n_state = S_TY;
            S_TY:   n_state = S_UY;
            S_UY:   n_state = S_MX;
            S_MX:   n_state = S_MY;
            S_MY:   n_state = S_LIM;
            S_LIM:  n_state = S_CMP;
            S_CMP:  if (w_cmp_go) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= nss_pkg::LIMIT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_ax_neg <= w_ax_sm[C];
            r_ax_mag <= w_ax_sm[C-1:0];
            r_ay_neg <= w_ay_sm[C];
            r_ay_mag <= w_ay_sm[C-1:0];
            r_dx_neg <= w_dx_sm[C];
            r_dx_mag <= w_dx_sm[C-1:0];
            r_dy_neg <= w_dy_sm[C];
            r_dy_mag <= w_dy_sm[C-1:0];
            r_last   <= s_axis_tlast;
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b1;
        case (r_state)
            S_PX: begin
                w_mul_a = MW'(r_ax_mag);
                w_mul_b = MW'(r_dx_mag);
            end
            S_PY: begin
                w_mul_a = MW'(r_ay_mag);
                w_mul_b = MW'(r_dy_mag);
            end
            S_DXX: begin
                w_mul_a = MW'(r_dx_mag);
                w_mul_b = MW'(r_dx_mag);
            end
            S_DYY: begin
                w_mul_a = MW'(r_dy_mag);
                w_mul_b = MW'(r_dy_mag);
            end
            S_TX: begin
                w_mul_a = MW'(r_t);
                w_mul_b = MW'(r_dx_mag);
            end
            S_TY: begin
                w_mul_a = MW'(r_t);
                w_mul_b = MW'(r_dy_mag);
            end
            S_MX: begin
                w_mul_a = MW'(r_mx[SQ_IN_W-1:0]);
                w_mul_b = MW'(r_mx[SQ_IN_W-1:0]);
            end
            S_MY: begin
                w_mul_a = MW'(r_my[SQ_IN_W-1:0]);
                w_mul_b = MW'(r_my[SQ_IN_W-1:0]);
            end
            S_LIM: begin
                w_mul_a = MW'(r_limit);
                w_mul_b = MW'(r_limit);
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
    end

    // ---------------- projection factor ----------------
    assign w_term       = DOT_W'(r_prod[2*C-1:0]);
    assign w_dot_nonpos = r_dot[DOT_W-1] || (r_dot == '0);
    assign w_dot_ge_den = (r_dot >= DOT_W'(r_den));
    assign w_div_start  = (r_state == S_TSEL) && !w_dot_nonpos && !w_dot_ge_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t <= '0;
        end else begin
            case (r_state)
                S_PY:  r_dot <= (r_ax_neg ^ r_dx_neg) ? (DOT_W'(0) - w_term) : w_term;
                S_DXX: r_dot <= (r_ay_neg ^ r_dy_neg) ? (r_dot - w_term) : (r_dot + w_term);
                S_DYY: r_den <= DEN_W'(r_prod[2*C-1:0]);
                S_DEN: r_den <= r_den + DEN_W'(r_prod[2*C-1:0]);
                S_TSEL: begin
                    // A zero length segment gives a zero dot product and so a factor of zero.
                    if (w_dot_nonpos) begin
                        r_t <= '0;
                    end else if (w_dot_ge_den) begin
                        r_t <= T_W'(1) << F;
                    end
                end
                S_DIV: if (w_div_sts.done) begin
                    r_t <= {1'b0, w_div_quo};
                end
                default: ;
            endcase
        end
    end

    nss_div #(
        .NUM_W (DEN_W),
        .QUO_W (F)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (r_dot[DEN_W-1:0]),
        .i_den    (r_den),
        .o_quo    (w_div_quo),
        .o_status (w_div_sts)
    );

    // ---------------- offset of the projected point and squared distance ----------------
    // The offset from the query is (start - query) * 2**F + t * d; start - query is -a.
    assign w_back_x = U_W'({r_ax_mag, F'(0)});
    assign w_back_y = U_W'({r_ay_mag, F'(0)});
    assign w_tprod  = U_W'(r_prod[C+F:0]);
    assign w_sq     = DIST_W'(r_prod[2*SQ_IN_W-1:0]);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_TY: r_ux <= f_sadd(w_back_x, !r_ax_neg, w_tprod, r_dx_neg);
            S_UY: begin
                r_uy <= f_sadd(w_back_y, !r_ay_neg, w_tprod, r_dy_neg);
                r_mx <= f_abs(r_ux);
            end
            S_MX: begin
                r_my     <= f_abs(r_uy);
                r_near_x <= (r_mx[M_W-1:SQ_IN_W] == '0);
            end
            S_MY: begin
                r_dist   <= w_sq;
                r_near_y <= (r_my[M_W-1:SQ_IN_W] == '0);
            end
            S_LIM: r_dist <= r_dist + w_sq;
            default: ;
        endcase
    end

    // ---------------- search state ----------------
    // Until a segment is found the live limit applies; r_prod holds its square here.
    assign w_thr      = r_have_best ? r_best_sq
                                    : (DIST_W'(r_prod[LIM2_W-1:0]) << (2 * F));
    assign w_cand     = r_near_x && r_near_y && (r_dist < w_thr);
    assign w_new_have = r_have_best || w_cand;
    assign w_new_sq   = w_cand ? r_dist : r_best_sq;
    assign w_new_pos  = w_cand ? r_count : r_best_pos;
    assign w_pos_ext  = IDX_X_W'(w_new_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
            r_count     <= '0;
        end else if (w_cmp_go) begin
            if (r_last) begin
                r_have_best <= 1'b0;
                r_count     <= '0;
            end else begin
                r_have_best <= w_new_have;
                r_count     <= (r_count == CNT_W'(MAX_SEGMENTS - 1)) ? '0
                                                                     : r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmp_go && !r_last) begin
            r_best_sq  <= w_new_sq;
            r_best_pos <= w_new_pos;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmp_go && r_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmp_go && r_last) begin
            r_out_found <= w_new_have;
            r_out_index <= w_new_have ? w_pos_ext[nss_pkg::INDEX_W-1:0] : '0;
            r_out_dist  <= w_new_have ? w_new_sq[OUT_LSB +: nss_pkg::DIST_OUT_W] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = nss_pkg::OUT_DATA_W'({r_out_dist, r_out_index});

    // ---------------- assertions ----------------
    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.busy |-> (r_state == S_DIV))
        else $error("divider busy outside the divide state");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmp_go && r_last |=> m_axis_tvalid && (m_axis_tuser == $past(w_new_have)))
        else $error("result of a last item not presented");

    a_t_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t[F] |-> (r_t[F-1:0] == '0))
        else $error("projection factor above one");

endmodule

`default_nettype wire
